FILE: hdl/edbp_pkg.sv
`default_nettype none

package edbp_pkg;

   // Fixed sizes of the block and of the result fields.
   localparam int unsigned NAME_MAX_DEF = 13;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned CHAR_W       = 7;
   localparam int unsigned SIZE_W       = 12;
   localparam int unsigned LEN_W        = 4;
   localparam int unsigned POS_W        = 8;
   localparam int unsigned OFF_W        = 5;

   localparam logic [POS_W-1:0] BLOCK_BYTES = 8'd128;

   // Byte positions inside the base block.
   localparam logic [POS_W-1:0] POS_HDR0   = 8'd0;
   localparam logic [POS_W-1:0] POS_HDR1   = 8'd1;
   localparam logic [POS_W-1:0] POS_HDR7   = 8'd7;
   localparam logic [POS_W-1:0] POS_WLO    = 8'd56;
   localparam logic [POS_W-1:0] POS_WHI    = 8'd58;
   localparam logic [POS_W-1:0] POS_HLO    = 8'd59;
   localparam logic [POS_W-1:0] POS_HHI    = 8'd61;
   localparam logic [POS_W-1:0] DESC_FIRST = 8'd54;
   localparam logic [POS_W-1:0] DESC_END   = 8'd126;

   // Offsets inside one descriptor.
   localparam logic [OFF_W-1:0] OFF_TAG0     = 5'd0;
   localparam logic [OFF_W-1:0] OFF_TAG1     = 5'd1;
   localparam logic [OFF_W-1:0] OFF_TAG_TYPE = 5'd3;
   localparam logic [OFF_W-1:0] OFF_TEXT     = 5'd5;
   localparam logic [OFF_W-1:0] OFF_LAST     = 5'd17;

   // Byte codes.
   localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_FF   = 8'hFF;
   localparam logic [BYTE_W-1:0] TAG_NAME  = 8'hFC;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TILDE  = 8'h7E;

   // Microprogram step addresses.
   typedef logic [1:0] edbp_step_type;
   localparam edbp_step_type STEP_INTAKE  = 2'd0;
   localparam edbp_step_type STEP_LATCH   = 2'd1;
   localparam edbp_step_type STEP_CHARS   = 2'd2;
   localparam edbp_step_type STEP_SUMMARY = 2'd3;

   // Jump conditions.
   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_LAST,
      COND_IDX_DONE,
      COND_OUT_FREE
   } edbp_cond_type;

   // One control word of the microprogram.
   typedef struct packed {
      logic          accept;
      logic          load_len;
      logic          emit_char;
      logic          emit_sum;
      edbp_cond_type cond;
      edbp_step_type target;
   } edbp_cw_type;

   // Status that the datapath returns to the sequencer.
   typedef struct packed {
      logic last_in;
      logic idx_done;
      logic out_free;
   } edbp_status_type;

   // The control store. A step that does not meet its condition stays put.
   function automatic edbp_cw_type edbp_ucode(input edbp_step_type step);
      edbp_cw_type cw;
      cw = '{accept: 1'b0, load_len: 1'b0, emit_char: 1'b0, emit_sum: 1'b0,
             cond: COND_ALWAYS, target: STEP_INTAKE};
      case (step)
         STEP_INTAKE: begin
            cw.accept = 1'b1;
            cw.cond   = COND_LAST;
            cw.target = STEP_LATCH;
         end
         STEP_LATCH: begin
            cw.load_len = 1'b1;
            cw.cond     = COND_ALWAYS;
            cw.target   = STEP_CHARS;
         end
         STEP_CHARS: begin
            cw.emit_char = 1'b1;
            cw.cond      = COND_IDX_DONE;
            cw.target    = STEP_SUMMARY;
         end
         STEP_SUMMARY: begin
            cw.emit_sum = 1'b1;
            cw.cond     = COND_OUT_FREE;
            cw.target   = STEP_INTAKE;
         end
         default: begin
            cw.cond   = COND_ALWAYS;
            cw.target = STEP_INTAKE;
         end
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/edbp_sequencer.sv
`default_nettype none

module edbp_sequencer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire edbp_pkg::edbp_status_type status,
   output edbp_pkg::edbp_cw_type          cw
);
   import edbp_pkg::*;

   edbp_step_type step_ff;
   edbp_step_type step_in;
   logic          cond_true;

   // Fetch the control word of the current step.
   assign cw = edbp_ucode(step_ff);

   // Evaluate the jump condition of the current step.
   always_comb begin
      case (cw.cond)
         COND_ALWAYS:   cond_true = 1'b1;
         COND_LAST:     cond_true = status.last_in;
         COND_IDX_DONE: cond_true = status.idx_done;
         COND_OUT_FREE: cond_true = status.out_free;
         default:       cond_true = 1'b0;
      endcase
      step_in = cond_true ? cw.target : step_ff;
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_INTAKE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/edbp_datapath.sv
`default_nettype none

module edbp_datapath #(
   parameter int unsigned NAME_MAX = edbp_pkg::NAME_MAX_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire edbp_pkg::edbp_cw_type             cw,
   output edbp_pkg::edbp_status_type              status,
   input  wire logic                              req_valid,
   input  wire logic [edbp_pkg::BYTE_W-1:0]       req_edid_byte,
   input  wire logic                              req_end_of_block,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [edbp_pkg::CHAR_W-1:0]            rsp_name_char,
   output logic                                   rsp_is_summary,
   output logic [edbp_pkg::SIZE_W-1:0]            rsp_active_width,
   output logic [edbp_pkg::SIZE_W-1:0]            rsp_active_height,
   output logic                                   rsp_timing_valid,
   output logic [edbp_pkg::LEN_W-1:0]             rsp_name_length,
   output logic                                   rsp_last_of_run
);
   import edbp_pkg::*;

   localparam int unsigned IDX_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
   localparam logic [LEN_W-1:0] NAME_LIM = LEN_W'(NAME_MAX);

   // Parse state.
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic              header_ok_ff, header_ok_in;
   logic [7:0]        width_lo_ff, width_lo_in;
   logic [3:0]        width_hi_ff, width_hi_in;
   logic [7:0]        height_lo_ff, height_lo_in;
   logic [3:0]        height_hi_ff, height_hi_in;
   logic              desc_match_ff, desc_match_in;
   logic              name_found_ff, name_found_in;
   logic              name_term_ff, name_term_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  trimmed_ff, trimmed_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [CHAR_W-1:0] name_store [NAME_MAX];
   logic              store_we;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic              rsp_sum_ff;
   logic [SIZE_W-1:0] rsp_width_ff, rsp_height_ff;
   logic              rsp_tv_ff;
   logic [LEN_W-1:0]  rsp_len_ff;

   logic              take;
   logic              in_block;
   logic              in_desc;
   logic              out_free;
   logic              fire_char;
   logic              fire_sum;
   logic              block_ok;
   logic [SIZE_W-1:0] size_w;
   logic [SIZE_W-1:0] size_h;
   logic              timing_ok;
   logic              is_text;
   logic [BYTE_W-1:0] b;

   assign b         = req_edid_byte;
   assign take      = cw.accept && req_valid;
   assign in_block  = pos_ff < BLOCK_BYTES;
   assign in_desc   = (pos_ff >= DESC_FIRST) && (pos_ff < DESC_END);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire_char = cw.emit_char && (idx_ff != len_ff) && out_free;
   assign fire_sum  = cw.emit_sum && out_free;
   assign is_text   = (b >= CH_SPACE) && (b <= CH_TILDE);

   // Summary values from the collected state.
   assign block_ok  = header_ok_ff && (pos_ff >= BLOCK_BYTES);
   assign size_w    = {width_hi_ff, width_lo_ff};
   assign size_h    = {height_hi_ff, height_lo_ff};
   assign timing_ok = block_ok && (size_w != '0) && (size_h != '0);

   assign status.last_in  = take && req_end_of_block;
   assign status.idx_done = (idx_ff == len_ff);
   assign status.out_free = out_free;

   // Next state of the parser for one accepted byte, and the run counters.
   always_comb begin
      pos_in        = pos_ff;
      off_in        = off_ff;
      header_ok_in  = header_ok_ff;
      width_lo_in   = width_lo_ff;
      width_hi_in   = width_hi_ff;
      height_lo_in  = height_lo_ff;
      height_hi_in  = height_hi_ff;
      desc_match_in = desc_match_ff;
      name_found_in = name_found_ff;
      name_term_in  = name_term_ff;
      count_in      = count_ff;
      trimmed_in    = trimmed_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      store_we      = 1'b0;

      if (take && in_block) begin
         pos_in = pos_ff + 8'd1;
         if ((pos_ff == POS_HDR0 && b != BYTE_ZERO) ||
             (pos_ff == POS_HDR1 && b != BYTE_FF) ||
             (pos_ff == POS_HDR7 && b != BYTE_ZERO)) begin
            header_ok_in = 1'b0;
         end
         if (pos_ff == POS_WLO) width_lo_in  = b;
         if (pos_ff == POS_WHI) width_hi_in  = b[7:4];
         if (pos_ff == POS_HLO) height_lo_in = b;
         if (pos_ff == POS_HHI) height_hi_in = b[7:4];

         if (in_desc) begin
            off_in = (off_ff == OFF_LAST) ? '0 : off_ff + 5'd1;
            if (!name_found_ff) begin
               if (off_ff == OFF_TAG0) begin
                  desc_match_in = (b == BYTE_ZERO);
               end else if (off_ff == OFF_TAG1) begin
                  desc_match_in = desc_match_ff && (b == BYTE_ZERO);
               end else if (off_ff == OFF_TAG_TYPE) begin
                  if (desc_match_ff && b == TAG_NAME) begin
                     name_found_in = 1'b1;
                     name_term_in  = 1'b0;
                     count_in      = '0;
                     trimmed_in    = '0;
                  end
               end
            end else if (!name_term_ff && off_ff >= OFF_TEXT) begin
               if (b == CH_LF || b == BYTE_ZERO) begin
                  name_term_in = 1'b1;
               end else if (is_text && count_ff < NAME_LIM) begin
                  store_we = 1'b1;
                  count_in = count_ff + 4'd1;
                  if (b != CH_SPACE) trimmed_in = count_ff + 4'd1;
               end
               if (off_ff == OFF_LAST) name_term_in = 1'b1;
            end
         end
      end

      if (cw.load_len) begin
         len_in = block_ok ? trimmed_ff : '0;
         idx_in = '0;
      end
      if (fire_char) idx_in = idx_ff + 4'd1;
   end

   // Result register: loads when a result is produced, empties when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire_char || fire_sum) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state, cleared by reset and at the end of each run.
   always_ff @(posedge clock) begin
      if (reset || fire_sum) begin
         pos_ff        <= '0;
         off_ff        <= '0;
         header_ok_ff  <= 1'b1;
         width_lo_ff   <= '0;
         width_hi_ff   <= '0;
         height_lo_ff  <= '0;
         height_hi_ff  <= '0;
         desc_match_ff <= 1'b1;
         name_found_ff <= 1'b0;
         name_term_ff  <= 1'b0;
         count_ff      <= '0;
         trimmed_ff    <= '0;
         len_ff        <= '0;
         idx_ff        <= '0;
      end else begin
         pos_ff        <= pos_in;
         off_ff        <= off_in;
         header_ok_ff  <= header_ok_in;
         width_lo_ff   <= width_lo_in;
         width_hi_ff   <= width_hi_in;
         height_lo_ff  <= height_lo_in;
         height_hi_ff  <= height_hi_in;
         desc_match_ff <= desc_match_in;
         name_found_ff <= name_found_in;
         name_term_ff  <= name_term_in;
         count_ff      <= count_in;
         trimmed_ff    <= trimmed_in;
         len_ff        <= len_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Name character store.
   always_ff @(posedge clock) begin
      if (store_we) begin
         name_store[count_ff[IDX_W-1:0]] <= b[CHAR_W-1:0];
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (fire_char) begin
         rsp_char_ff   <= name_store[idx_ff[IDX_W-1:0]];
         rsp_sum_ff    <= 1'b0;
         rsp_width_ff  <= '0;
         rsp_height_ff <= '0;
         rsp_tv_ff     <= 1'b0;
         rsp_len_ff    <= '0;
      end else if (fire_sum) begin
         rsp_char_ff   <= '0;
         rsp_sum_ff    <= 1'b1;
         rsp_width_ff  <= timing_ok ? size_w : '0;
         rsp_height_ff <= timing_ok ? size_h : '0;
         rsp_tv_ff     <= timing_ok;
         rsp_len_ff    <= len_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_name_char     = rsp_char_ff;
   assign rsp_is_summary    = rsp_sum_ff;
   assign rsp_active_width  = rsp_width_ff;
   assign rsp_active_height = rsp_height_ff;
   assign rsp_timing_valid  = rsp_tv_ff;
   assign rsp_name_length   = rsp_len_ff;
   assign rsp_last_of_run   = rsp_sum_ff;

endmodule

`default_nettype wire

FILE: hdl/edid_block_parser.sv
`default_nettype none

// EDID base block parser.
// The req_ channel carries one EDID byte per transaction, starting at byte 0,
// with req_end_of_block set on the final byte. The rsp_ channel returns the
// monitor name characters, one per transaction, followed by one summary
// transaction that carries the native size, the timing flag and the name
// length; the summary also has rsp_last_of_run set.
// While a block streams in, one byte is taken every cycle. After the final
// byte, the sequencer runs its emission program: a setup step that latches
// the name length, a character step that loads the name characters into the
// output register one per cycle while rsp_ does not stall and then exits,
// and a summary step; the input stays stalled through all of them. The first
// character is loaded by the character step, after the setup step; with an
// empty name the summary follows the setup step and an empty character step.
// A stall on rsp_ holds the result register and pauses the program; a new
// byte is taken as soon as the summary has been loaded into that register.
// Reset is synchronous and returns the parser to byte 0 with an empty output.
// After each summary the parser also returns to byte 0 for the next block.
module edid_block_parser #(
   parameter int unsigned NAME_MAX = edbp_pkg::NAME_MAX_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [edbp_pkg::BYTE_W-1:0] req_edid_byte,
   input  wire logic                        req_end_of_block,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [edbp_pkg::CHAR_W-1:0]      rsp_name_char,
   output logic                             rsp_is_summary,
   output logic [edbp_pkg::SIZE_W-1:0]      rsp_active_width,
   output logic [edbp_pkg::SIZE_W-1:0]      rsp_active_height,
   output logic                             rsp_timing_valid,
   output logic [edbp_pkg::LEN_W-1:0]       rsp_name_length,
   output logic                             rsp_last_of_run
);
   import edbp_pkg::*;

   edbp_cw_type     cw;
   edbp_status_type status;

   // Input is taken only in the intake step of the program.
   assign req_stall = !cw.accept;

   edbp_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw)
   );

   edbp_datapath #(
      .NAME_MAX (NAME_MAX)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cw                (cw),
      .status            (status),
      .req_valid         (req_valid),
      .req_edid_byte     (req_edid_byte),
      .req_end_of_block  (req_end_of_block),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_name_char     (rsp_name_char),
      .rsp_is_summary    (rsp_is_summary),
      .rsp_active_width  (rsp_active_width),
      .rsp_active_height (rsp_active_height),
      .rsp_timing_valid  (rsp_timing_valid),
      .rsp_name_length   (rsp_name_length),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

`default_nettype wire
